>>> sv/tipe_pkg.sv
`timescale 1ns / 1ps
package tipe_pkg;
  localparam int MAX_RANK_DEF = 4;
  localparam int TENSOR_DEPTH_DEF = 4096;
  localparam int VALUE_DEPTH_DEF = 4096;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int NUM_DIMS = 4;
  localparam int DIM_W = 13;
  localparam int IDX_W = 13;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 13;
  localparam int POS_W = 12;
  localparam int CNT_W = 12;
  localparam int ACTION_W = 2;

  localparam logic [ACTION_W-1:0] ACT_LOAD_T = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD_V = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_PUT    = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_READ   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DIM0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIM3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RANK  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ICNT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ACCUM = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_VCNT  = 3'd7;
endpackage

>>> sv/tensor_index_put_engine_core.sv
`timescale 1ns / 1ps
// Tensor index-put engine. One command is taken when start is high and busy
// is low; its single result (read_value, status) appears for one cycle with
// out_valid, and the receiver cannot stall it. Loads and reads pass through
// S_RWAIT and S_RDONE before their registered result.
// A put checks and wraps one index per step. It forms the strides, the
// row-major offset and the trailing block length on one shared 13x40
// multiplier, with one multiply per stride factor, per index term and per
// trailing dimension. A full tuple then reduces the put count modulo
// value_count by shift and subtract, one count bit per step. Each element
// then is read in S_VRD and written back in S_WR through the tensor memory's
// write port, and the next element waits for that write.
// A put rejected at any index goes from S_IDX straight to S_DONE. A block
// put writes up to 4096 elements.
module tensor_index_put_engine_core
  import tipe_pkg::*;
#(
  parameter int MAX_RANK     = MAX_RANK_DEF,
  parameter int TENSOR_DEPTH = TENSOR_DEPTH_DEF,
  parameter int VALUE_DEPTH  = VALUE_DEPTH_DEF,
  parameter int DATA_WIDTH   = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [ACTION_W-1:0]          in_action,
  input  logic [POS_W-1:0]             in_position,
  input  logic signed [DATA_WIDTH-1:0] in_data_value,
  input  logic signed [IDX_W-1:0]      in_index_0,
  input  logic signed [IDX_W-1:0]      in_index_1,
  input  logic signed [IDX_W-1:0]      in_index_2,
  input  logic signed [IDX_W-1:0]      in_index_3,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_read_value,
  output logic                         out_status
);
  localparam int TA_W = $clog2(TENSOR_DEPTH);
  localparam int VA_W = (VALUE_DEPTH > 1) ? $clog2(VALUE_DEPTH) : 1;
  localparam int LIM  = (MAX_RANK < NUM_DIMS) ? MAX_RANK : NUM_DIMS;
  localparam int ACC_W = 40;
  localparam int LEN_W = TA_W + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RWAIT = 4'd1;
  localparam logic [3:0] S_RDONE = 4'd2;
  localparam logic [3:0] S_IDX   = 4'd3;
  localparam logic [3:0] S_STR   = 4'd4;
  localparam logic [3:0] S_LEN   = 4'd5;
  localparam logic [3:0] S_VRD   = 4'd6;
  localparam logic [3:0] S_WR    = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;
  localparam logic [3:0] S_MOD   = 4'd9;

  // configuration registers
  logic [DIM_W-1:0] dim_r [NUM_DIMS];
  logic [2:0]       rank_cfg_r, icnt_cfg_r;
  logic             accum_r;
  logic [DIM_W-1:0] vcnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_DIMS; i++) dim_r[i] <= DIM_W'(1);
      rank_cfg_r <= 3'd1;
      icnt_cfg_r <= 3'd1;
      accum_r    <= 1'b0;
      vcnt_r     <= DIM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIM0:  dim_r[0] <= cfg_data;
        REG_DIM1:  dim_r[1] <= cfg_data;
        REG_DIM2:  dim_r[2] <= cfg_data;
        REG_DIM3:  dim_r[3] <= cfg_data;
        REG_RANK:  rank_cfg_r <= cfg_data[2:0];
        REG_ICNT:  icnt_cfg_r <= cfg_data[2:0];
        REG_ACCUM: accum_r <= cfg_data[0];
        REG_VCNT:  vcnt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective sizes with zero treated as one and clamps applied
  logic [DIM_W-1:0] dim_e [NUM_DIMS];
  logic [2:0] rank_e, icnt_e;
  logic [DIM_W-1:0] vcnt_e;
  always_comb begin
    for (int i = 0; i < NUM_DIMS; i++) begin
      dim_e[i] = (dim_r[i] == '0) ? DIM_W'(1) : dim_r[i];
    end
    rank_e = (rank_cfg_r == '0) ? 3'd1 : rank_cfg_r;
    if (rank_e > 3'(LIM)) rank_e = 3'(LIM);
    icnt_e = (icnt_cfg_r == '0) ? 3'd1 : icnt_cfg_r;
    if (icnt_e > rank_e) icnt_e = rank_e;
    vcnt_e = (vcnt_r == '0) ? DIM_W'(1) : vcnt_r;
  end

  // control and working registers
  logic [3:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r;
  logic [ACTION_W-1:0]    act_r;
  logic [POS_W-1:0]       pos_r;
  logic [IDX_W-1:0]       ix_r [NUM_DIMS];
  logic [2:0]             k_r, m_r;
  logic [ACC_W-1:0]       stride_r, offset_r;
  logic [IDX_W-1:0]       cur_ix_r;
  logic [LEN_W-1:0]       len_r, j_r;
  logic [DIM_W-1:0]       vsel_r;
  logic [3:0]             bit_r;
  logic                   full_r;
  logic                   out_valid_r, out_status_r, out_rd_r;

  // shared multiplier
  logic [DIM_W-1:0] mul_a;
  logic [ACC_W-1:0] mul_b, mul_p;
  assign mul_p = ACC_W'({{(ACC_W-DIM_W){1'b0}}, mul_a} * mul_b);

  // one remainder step: shift in the next count bit, subtract if it fits
  logic [DIM_W:0] mod_sh;
  assign mod_sh = {vsel_r, cnt_r[bit_r]};

  // wrapped index of the current dimension
  logic signed [IDX_W+1:0] ixw;
  logic ix_ok;
  always_comb begin
    ixw = {{2{ix_r[k_r[1:0]][IDX_W-1]}}, ix_r[k_r[1:0]]};
    if (ixw < 0) ixw = ixw + $signed({2'b00, dim_e[k_r[1:0]]});
    ix_ok = (ixw >= 0) && (ixw < $signed({2'b00, dim_e[k_r[1:0]]}));
  end

  // memories
  logic t_we, v_we;
  logic [TA_W-1:0] t_waddr, t_raddr;
  logic [DATA_WIDTH-1:0] t_wdata, t_rdata, v_rdata;
  logic [VA_W-1:0] v_raddr;
  logic [TA_W-1:0] elem_addr;
  assign elem_addr = TA_W'(offset_r + ACC_W'(j_r));

  tipe_ram #(.WIDTH(DATA_WIDTH), .DEPTH(TENSOR_DEPTH)) u_tensor (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata));
  tipe_ram #(.WIDTH(DATA_WIDTH), .DEPTH(VALUE_DEPTH)) u_value (
    .clk(clk), .we(v_we), .waddr(VA_W'(in_position)), .wdata(in_data_value),
    .raddr(v_raddr), .rdata(v_rdata));

  logic accept;
  assign accept = start && !busy;
  assign busy = (state_r != S_IDLE);
  assign v_we = accept && (in_action == ACT_LOAD_V);
  // hold the read address of a read or load until its result goes out
  assign t_raddr = (state_r == S_IDLE) ? TA_W'(in_position) :
                   (state_r == S_RWAIT || state_r == S_RDONE) ? TA_W'(pos_r) :
                   elem_addr;
  assign v_raddr = VA_W'(vsel_r);

  always_comb begin
    t_we = 1'b0;
    t_waddr = elem_addr;
    t_wdata = accum_r ? (t_rdata + v_rdata) : v_rdata;
    if (accept && in_action == ACT_LOAD_T) begin
      t_we = 1'b1;
      t_waddr = TA_W'(in_position);
      t_wdata = in_data_value;
    end else if (state_r == S_WR) begin
      t_we = 1'b1;
    end
  end

  // multiplier operand select: index term on the last step of each index
  always_comb begin
    mul_a = (state_r == S_STR && m_r >= rank_e) ? cur_ix_r : dim_e[m_r[1:0]];
    mul_b = stride_r;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = (in_action == ACT_PUT) ? S_IDX : S_RWAIT;
      S_RWAIT: state_nxt = S_RDONE;
      S_RDONE: state_nxt = S_IDLE;
      S_IDX:   state_nxt = !ix_ok ? S_DONE : S_STR;
      S_STR:   if (m_r >= rank_e) state_nxt = (k_r + 3'd1 >= icnt_e) ? S_LEN : S_IDX;
      S_LEN:   if (m_r >= rank_e) state_nxt = full_r ? S_MOD : S_VRD;
      S_MOD:   if (bit_r == '0) state_nxt = S_VRD;
      S_VRD:   state_nxt = S_WR;
      S_WR:    state_nxt = (j_r + LEN_W'(1) >= len_r) ? S_DONE : S_VRD;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= (state_r == S_RDONE) || (state_r == S_DONE);
      if (accept && (in_action == ACT_LOAD_T || in_action == ACT_LOAD_V)) begin
        cnt_r <= '0;
      end else if (state_r == S_WR && state_nxt == S_DONE) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        act_r <= in_action;
        pos_r <= in_position;
        ix_r[0] <= in_index_0;
        ix_r[1] <= in_index_1;
        ix_r[2] <= in_index_2;
        ix_r[3] <= in_index_3;
        k_r <= '0;
        offset_r <= '0;
        out_rd_r <= 1'b0;
        out_status_r <= 1'b0;
      end
      S_RWAIT: ;
      S_RDONE: out_rd_r <= (act_r == ACT_READ);
      S_IDX: begin
        out_status_r <= !ix_ok;
        cur_ix_r <= IDX_W'(ixw);
        stride_r <= ACC_W'(1);
        m_r <= k_r + 3'd1;
      end
      S_STR: begin
        if (m_r < rank_e) begin
          stride_r <= mul_p;
          m_r <= m_r + 3'd1;
        end else begin
          offset_r <= offset_r + mul_p;
          k_r <= k_r + 3'd1;
          if (k_r + 3'd1 >= icnt_e) begin
            m_r <= k_r + 3'd1;
            stride_r <= ACC_W'(1);
            full_r <= (k_r + 3'd1 >= rank_e);
          end
        end
      end
      S_LEN: begin
        if (m_r < rank_e) begin
          stride_r <= (mul_p > ACC_W'(TENSOR_DEPTH)) ? ACC_W'(TENSOR_DEPTH) : mul_p;
          m_r <= m_r + 3'd1;
        end else begin
          len_r <= LEN_W'(stride_r);
          j_r <= '0;
          vsel_r <= '0;
          bit_r <= 4'(CNT_W - 1);
        end
      end
      S_MOD: begin
        vsel_r <= (mod_sh >= {1'b0, vcnt_e}) ? DIM_W'(mod_sh - {1'b0, vcnt_e})
                                             : DIM_W'(mod_sh);
        bit_r <= bit_r - 4'd1;
      end
      S_VRD: ;
      S_WR: begin
        j_r <= j_r + LEN_W'(1);
        if (!full_r) vsel_r <= (vsel_r + DIM_W'(1) >= vcnt_e) ? '0 : vsel_r + DIM_W'(1);
      end
      S_DONE: ;
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_read_value = out_rd_r ? t_rdata : '0;
endmodule

>>> sv/tipe_ram.sv
`timescale 1ns / 1ps
module tipe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
